[sv/ptq_pkg.sv]
// Package for the two-level priority task queue.
// Holds status and command codes, field widths, default sizes and the bank control struct.
// No dependencies.
package ptq_pkg;

    localparam int NORMAL_DEPTH_DEF    = 256;
    localparam int INTERRUPT_DEPTH_DEF = 256;
    localparam int ID_BITS_DEF         = 8;

    localparam int PRIO_BITS   = 4;
    localparam int PORT_ID_BITS = 8;
    localparam int STATUS_BITS = 2;
    localparam int TDATA_BITS  = 16;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_ENQUEUED   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_DISPATCHED = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY      = 2'd3;

    typedef struct packed {
        logic we;
        logic push;
        logic pop;
    } ptq_bank_ctl_t;

endpackage

[sv/ptq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ptq_bank.sv]
// One sorted task queue: circular RAM with head pointer and fill count.
// Logical indexes are relative to the front. Depends on ptq_pkg and ptq_ram.
module ptq_bank
    import ptq_pkg::*;
#(
    parameter int DEPTH      = NORMAL_DEPTH_DEF,
    parameter int ENTRY_BITS = ID_BITS_DEF + PRIO_BITS,
    parameter int IDX_BITS   = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ptq_bank_ctl_t         ctl,
    input  logic [IDX_BITS-1:0]   ridx,
    input  logic [IDX_BITS-1:0]   widx,
    input  logic [ENTRY_BITS-1:0] wdata,
    output logic [ENTRY_BITS-1:0] rdata,
    output logic [IDX_BITS-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IDX_BITS + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] raddr, waddr;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [IDX_BITS-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    assign raddr = phys(head_reg, ridx);
    assign waddr = phys(head_reg, widx);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.pop) begin
            head_next  = phys(head_reg, IDX_BITS'(1));
            count_next = count_reg - CW'(1);
        end else if (ctl.push) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    ptq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign count = IDX_BITS'(count_reg);

endmodule

[sv/two_level_priority_task_queue.sv]
// Two-level priority task queue: interrupt and normal queues kept sorted in RAM.
// Enqueue walks back from the tail with one shared compare per entry (INS_RD, INS_CMP),
// shifting less urgent entries back, then writes the task (INS_PUT). Tick: POP_RD, POP_DATA;
// full or both empty go to EMIT. One item at a time; ready returns as the output loads.
// aresetn (synchronous, active low) empties both queues; RAM contents are not cleared.
// Depends on ptq_pkg and ptq_bank.
module two_level_priority_task_queue
    import ptq_pkg::*;
#(
    parameter int NORMAL_DEPTH    = NORMAL_DEPTH_DEF,
    parameter int INTERRUPT_DEPTH = INTERRUPT_DEPTH_DEF,
    parameter int ID_BITS         = ID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // task_id[7:0], task_priority[11:8]
    input  logic [1:0]            s_tuser,   // command[0], to_normal_queue[1]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // dispatched_id[7:0], dispatched_priority[11:8]
    output logic [2:0]            m_tuser    // status[1:0], from_interrupt_queue[2]
);

    localparam int MAX_DEPTH  = (NORMAL_DEPTH > INTERRUPT_DEPTH) ? NORMAL_DEPTH
                                                                 : INTERRUPT_DEPTH;
    localparam int IDX_BITS   = $clog2(MAX_DEPTH + 1);
    localparam int ENTRY_BITS = ID_BITS + PRIO_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_RD   = 3'd1;
    localparam logic [2:0] ST_INS_CMP  = 3'd2;
    localparam logic [2:0] ST_INS_PUT  = 3'd3;
    localparam logic [2:0] ST_POP_RD   = 3'd4;
    localparam logic [2:0] ST_POP_DATA = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic                   sel_reg, sel_next;        // 1 = normal queue
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [PRIO_BITS-1:0]   prio_reg, prio_next;
    logic [IDX_BITS-1:0]    k_reg, k_next;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [PORT_ID_BITS-1:0] res_id_reg, res_id_next;
    logic [PRIO_BITS-1:0]   res_prio_reg, res_prio_next;
    logic                   res_int_reg, res_int_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [PORT_ID_BITS-1:0] m_id_reg, m_id_next;
    logic [PRIO_BITS-1:0]   m_prio_reg, m_prio_next;
    logic                   m_int_reg, m_int_next;

    ptq_bank_ctl_t          ctl_n, ctl_i;
    logic                   bank_we, bank_push, bank_pop;
    logic [IDX_BITS-1:0]    ridx, widx;
    logic [ENTRY_BITS-1:0]  wdata, rdata_n, rdata_i, rd_entry;
    logic [IDX_BITS-1:0]    cnt_n, cnt_i, cnt_sel, depth_sel;
    logic [PRIO_BITS-1:0]   rd_prio;
    logic [ID_BITS-1:0]     rd_id;

    assign rd_entry  = sel_reg ? rdata_n : rdata_i;
    assign rd_prio   = rd_entry[ENTRY_BITS-1 -: PRIO_BITS];
    assign rd_id     = rd_entry[ID_BITS-1:0];
    assign cnt_sel   = s_tuser[1] ? cnt_n : cnt_i;
    assign depth_sel = s_tuser[1] ? IDX_BITS'(NORMAL_DEPTH) : IDX_BITS'(INTERRUPT_DEPTH);
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        res_int_next    = res_int_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_prio_next     = m_prio_reg;
        m_int_next      = m_int_reg;
        bank_we         = 1'b0;
        bank_push       = 1'b0;
        bank_pop        = 1'b0;
        ridx            = '0;
        widx            = k_reg;
        wdata           = {prio_reg, id_reg};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next         = ID_BITS'(s_tdata[PORT_ID_BITS-1:0]);
                    prio_next       = s_tdata[PORT_ID_BITS +: PRIO_BITS];
                    res_status_next = STATUS_ENQUEUED;
                    res_id_next     = '0;
                    res_prio_next   = '0;
                    res_int_next    = 1'b0;
                    if (s_tuser[0] == CMD_ENQUEUE) begin
                        sel_next = s_tuser[1];
                        k_next   = cnt_sel;
                        if (cnt_sel == depth_sel) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_EMIT;
                        end else if (cnt_sel == '0) begin
                            state_next = ST_INS_PUT;
                        end else begin
                            state_next = ST_INS_RD;
                        end
                    end else if (cnt_i != '0) begin
                        sel_next   = 1'b0;
                        state_next = ST_POP_RD;
                    end else if (cnt_n != '0) begin
                        sel_next   = 1'b1;
                        state_next = ST_POP_RD;
                    end else begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_INS_RD: begin
                ridx       = k_reg - IDX_BITS'(1);
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (rd_prio > prio_reg) begin
                    // shift the less urgent entry one place back
                    wdata      = rd_entry;
                    bank_we    = 1'b1;
                    k_next     = k_reg - IDX_BITS'(1);
                    state_next = (k_reg == IDX_BITS'(1)) ? ST_INS_PUT : ST_INS_RD;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                bank_we    = 1'b1;
                bank_push  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_POP_RD: begin
                state_next = ST_POP_DATA;
            end
            ST_POP_DATA: begin
                bank_pop        = 1'b1;
                res_status_next = STATUS_DISPATCHED;
                res_id_next     = PORT_ID_BITS'(rd_id);
                res_prio_next   = rd_prio;
                res_int_next    = !sel_reg;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = res_id_reg;
                    m_prio_next   = res_prio_reg;
                    m_int_next    = res_int_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl_n.we   = bank_we & sel_reg;
        ctl_n.push = bank_push & sel_reg;
        ctl_n.pop  = bank_pop & sel_reg;
        ctl_i.we   = bank_we & !sel_reg;
        ctl_i.push = bank_push & !sel_reg;
        ctl_i.pop  = bank_pop & !sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sel_reg        <= sel_next;
        id_reg         <= id_next;
        prio_reg       <= prio_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        res_int_reg    <= res_int_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_prio_reg     <= m_prio_next;
        m_int_reg      <= m_int_next;
    end

    ptq_bank #(
        .DEPTH      (NORMAL_DEPTH),
        .ENTRY_BITS (ENTRY_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_normal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_n),
        .ridx    (ridx),
        .widx    (widx),
        .wdata   (wdata),
        .rdata   (rdata_n),
        .count   (cnt_n)
    );

    ptq_bank #(
        .DEPTH      (INTERRUPT_DEPTH),
        .ENTRY_BITS (ENTRY_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_interrupt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_i),
        .ridx    (ridx),
        .widx    (widx),
        .wdata   (wdata),
        .rdata   (rdata_i),
        .count   (cnt_i)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_BITS - PORT_ID_BITS - PRIO_BITS){1'b0}}, m_prio_reg, m_id_reg};
    assign m_tuser  = {m_int_reg, m_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_n <= IDX_BITS'(NORMAL_DEPTH) && cnt_i <= IDX_BITS'(INTERRUPT_DEPTH))
        else $error("queue count beyond depth");

    a_idle_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_status_reg != STATUS_DISPATCHED
        |-> m_id_reg == '0 && m_prio_reg == '0 && !m_int_reg)
        else $error("non-dispatch result carries task fields");

    a_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(bank_push && bank_pop) && !(ctl_n.we && ctl_i.we))
        else $error("conflicting bank operations");

    a_walk_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INS_CMP |-> k_reg != '0)
        else $error("insertion walk past the front");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP_DATA |-> (sel_reg ? cnt_n : cnt_i) != '0)
        else $error("pop from an empty queue");

endmodule

[sim/testbench.sv]
// Self-checking testbench for two_level_priority_task_queue.
// Random and directed enqueue/tick items are checked against a behavioral queue model.
// Depends on ptq_pkg and the two_level_priority_task_queue RTL.
module testbench;
    import ptq_pkg::*;

    localparam int IRQ_LANE      = 0;
    localparam int NORMAL_LANE   = 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ITEMS  = 250;

    typedef struct packed {
        logic [7:0] id;
        logic [3:0] prio;
    } task_entry_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [7:0]             id;
        logic [3:0]             prio;
        logic                   from_irq;
    } outcome_t;

    class dispatch_predictor;
        task_entry_t lanes[2][$];
        outcome_t    pending_outcomes[$];
        int unsigned mismatches = 0;
        int unsigned enqueued   = 0;
        int unsigned dropped    = 0;
        int unsigned dispatched = 0;
        int unsigned empty_ticks = 0;

        function void note_command(logic cmd, logic [7:0] id, logic [3:0] prio,
                                   logic to_normal);
            outcome_t    o;
            task_entry_t e;
            int          pos;
            int          lane;
            int          depth;
            o = '0;
            if (cmd == CMD_ENQUEUE) begin
                lane  = to_normal ? NORMAL_LANE : IRQ_LANE;
                depth = to_normal ? NORMAL_DEPTH_DEF : INTERRUPT_DEPTH_DEF;
                if (lanes[lane].size() >= depth) begin
                    o.status = STATUS_FULL;
                    dropped++;
                end else begin
                    pos = 0;
                    while (pos < lanes[lane].size() && lanes[lane][pos].prio <= prio)
                        pos++;
                    e.id   = id;
                    e.prio = prio;
                    lanes[lane].insert(pos, e);
                    o.status = STATUS_ENQUEUED;
                    enqueued++;
                end
            end else begin
                if (lanes[IRQ_LANE].size() != 0)
                    lane = IRQ_LANE;
                else if (lanes[NORMAL_LANE].size() != 0)
                    lane = NORMAL_LANE;
                else
                    lane = -1;
                if (lane < 0) begin
                    o.status = STATUS_EMPTY;
                    empty_ticks++;
                end else begin
                    e          = lanes[lane].pop_front();
                    o.status   = STATUS_DISPATCHED;
                    o.id       = e.id;
                    o.prio     = e.prio;
                    o.from_irq = (lane == IRQ_LANE);
                    dispatched++;
                end
            end
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [STATUS_BITS-1:0] status, logic [7:0] id,
                                    logic [3:0] prio, logic from_irq);
            outcome_t o;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected item status=%0d id=%0d prio=%0d irq=%0d",
                         $time, status, id, prio, from_irq);
                mismatches++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (status !== o.status) begin
                $display("%0t: status expected %0d got %0d", $time, o.status, status);
                mismatches++;
            end
            if (id !== o.id) begin
                $display("%0t: dispatched_id expected %0d got %0d", $time, o.id, id);
                mismatches++;
            end
            if (prio !== o.prio) begin
                $display("%0t: dispatched_priority expected %0d got %0d",
                         $time, o.prio, prio);
                mismatches++;
            end
            if (from_irq !== o.from_irq) begin
                $display("%0t: from_interrupt_queue expected %0d got %0d",
                         $time, o.from_irq, from_irq);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [2:0]            m_tuser;

    logic steady   = 1'b0;
    logic hold_req = 1'b0;

    dispatch_predictor pred = new();

    two_level_priority_task_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        logic held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pred.check_outcome(m_tuser[1:0], m_tdata[7:0], m_tdata[11:8], m_tuser[2]);
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic offer_command(logic cmd, logic [7:0] id, logic [3:0] prio,
                                 logic to_normal);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, prio, id};
        s_tuser  <= {to_normal, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred.note_command(cmd, id, prio, to_normal);
    endtask

    task automatic offer_random_enqueue();
        offer_command(CMD_ENQUEUE, 8'($urandom_range(255)), 4'($urandom_range(15)),
                      1'($urandom_range(1)));
    endtask

    task automatic offer_tick();
        // fields are don't-care on a tick; drive junk
        offer_command(CMD_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)),
                      1'($urandom_range(1)));
    endtask

    initial begin
        int lane;
        logic [3:0] prio;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, extremes, equal-priority order, interrupt first
        offer_command(CMD_TICK, 8'h00, 4'h0, 1'b0);
        offer_command(CMD_TICK, 8'hFF, 4'hF, 1'b1);
        offer_command(CMD_ENQUEUE, 8'h00, 4'hF, 1'b1);
        offer_command(CMD_ENQUEUE, 8'hFF, 4'h0, 1'b1);
        offer_command(CMD_ENQUEUE, 8'h3C, 4'hF, 1'b1);
        offer_command(CMD_ENQUEUE, 8'hAA, 4'h7, 1'b0);
        offer_command(CMD_ENQUEUE, 8'h55, 4'h7, 1'b0);
        offer_command(CMD_ENQUEUE, 8'h01, 4'h0, 1'b0);
        offer_command(CMD_ENQUEUE, 8'hFE, 4'hF, 1'b0);
        offer_command(CMD_ENQUEUE, 8'h80, 4'h7, 1'b0);
        offer_command(CMD_TICK, 8'hFF, 4'hF, 1'b1);
        offer_command(CMD_TICK, 8'h00, 4'h0, 1'b0);
        offer_command(CMD_ENQUEUE, 8'h42, 4'h8, 1'b1);
        repeat (8) offer_tick();
        offer_command(CMD_TICK, 8'hA5, 4'h5, 1'b1);

        // mixed random traffic; the receiver stalls hard at the start
        hold_req = 1'b1;
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(99) < 40)
                offer_tick();
            else
                offer_random_enqueue();
        end

        // fill both queues to the top without gaps, then push into full queues
        steady = 1'b1;
        while (pred.lanes[IRQ_LANE].size() < INTERRUPT_DEPTH_DEF ||
               pred.lanes[NORMAL_LANE].size() < NORMAL_DEPTH_DEF) begin
            if (pred.lanes[IRQ_LANE].size() >= INTERRUPT_DEPTH_DEF)
                lane = NORMAL_LANE;
            else if (pred.lanes[NORMAL_LANE].size() >= NORMAL_DEPTH_DEF)
                lane = IRQ_LANE;
            else
                lane = $urandom_range(1);
            if ($urandom_range(15) == 0)
                lane = $urandom_range(1);
            prio = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'hF;
            offer_command(CMD_ENQUEUE, 8'($urandom_range(255)), prio, lane[0]);
        end
        repeat (12) offer_random_enqueue();
        steady = 1'b0;

        // drain, with a few enqueues mixed in
        while (pred.lanes[IRQ_LANE].size() != 0 || pred.lanes[NORMAL_LANE].size() != 0) begin
            if ($urandom_range(99) < 15)
                offer_random_enqueue();
            else
                offer_tick();
        end
        repeat (3) offer_tick();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pred.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pred.pending_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pred.pending_outcomes.size());
            pred.mismatches++;
        end
        $display("Covered %0d enqueues, %0d drops on full queues, %0d dispatches, %0d empty ticks",
                 pred.enqueued, pred.dropped, pred.dispatched, pred.empty_ticks);
        $display("Both queues were filled to depth and drained; %0d mismatches seen",
                 pred.mismatches);
        if (pred.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
